FILE: src/skvt_pkg.sv
// Shared types and constants for the sorted key/value table.
// No dependencies; used by skvt_ctrl, skvt_datapath and the top level.
`timescale 1ns / 1ps

package skvt_pkg;

   localparam int DEPTH_DEFAULT     = 16;
   localparam int KEY_WIDTH_DEFAULT = 32;
   localparam int VALUE_WIDTH       = 8;
   localparam int FUNC_WIDTH        = 2;
   localparam int STATUS_WIDTH      = 2;
   localparam int OUT_CNT_WIDTH     = 5;

   // Request operation codes; the unused code acts as a lookup.
   localparam logic [FUNC_WIDTH-1:0] FUNC_INSERT = 2'd0;
   localparam logic [FUNC_WIDTH-1:0] FUNC_ERASE  = 2'd1;
   localparam logic [FUNC_WIDTH-1:0] FUNC_LOOKUP = 2'd2;

   // Response status codes.
   localparam logic [STATUS_WIDTH-1:0] STATUS_DONE      = 2'd0;
   localparam logic [STATUS_WIDTH-1:0] STATUS_EXISTED   = 2'd1;
   localparam logic [STATUS_WIDTH-1:0] STATUS_NOT_FOUND = 2'd2;
   localparam logic [STATUS_WIDTH-1:0] STATUS_FULL      = 2'd3;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic capture;   // latch request and compare against every cell
      logic commit;    // apply the operation and load the response registers
   } dp_cmd_type;

endpackage

FILE: src/skvt_ctrl.sv
// Controller for the sorted key/value table: accept, execute, respond.
// Depends on skvt_pkg for the datapath command struct.
`timescale 1ns / 1ps

module skvt_ctrl (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output skvt_pkg::dp_cmd_type  cmd
);

   typedef enum logic {
      S_IDLE,
      S_EXEC
   } state_type;

   state_type state_ff;
   logic      rsp_valid_ff;
   logic      out_free;

   // Output register can take a new response this cycle.
   assign out_free    = !rsp_valid_ff || rsp_ready;
   // No transaction is taken while reset is held.
   assign req_ready   = (state_ff == S_IDLE) && !reset;
   assign rsp_valid   = rsp_valid_ff;
   assign cmd.capture = (state_ff == S_IDLE) && req_valid;
   assign cmd.commit  = (state_ff == S_EXEC) && out_free;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         unique case (state_ff)
            S_IDLE: begin
               if (rsp_ready) rsp_valid_ff <= 1'b0;
               if (req_valid) state_ff <= S_EXEC;
            end
            S_EXEC: begin
               if (out_free) begin
                  rsp_valid_ff <= 1'b1;
                  state_ff     <= S_IDLE;
               end
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

endmodule

FILE: src/skvt_datapath.sv
// Datapath for the sorted key/value table: a row of key/value cells with
// per-cell compare, shift-up/shift-down moves and the response registers.
// Depends on skvt_pkg for codes, widths and the command struct.
`timescale 1ns / 1ps

module skvt_datapath #(
   parameter  int DEPTH     = skvt_pkg::DEPTH_DEFAULT,
   parameter  int KEY_WIDTH = skvt_pkg::KEY_WIDTH_DEFAULT,
   localparam int CNT_W     = $clog2(DEPTH + 1)
) (
   input  logic                                   clock,
   input  logic                                   reset,
   input  skvt_pkg::dp_cmd_type                   cmd,
   input  logic [skvt_pkg::FUNC_WIDTH-1:0]        req_func,
   input  logic signed [KEY_WIDTH-1:0]            req_key,
   input  logic [skvt_pkg::VALUE_WIDTH-1:0]       req_value,
   output logic [skvt_pkg::STATUS_WIDTH-1:0]      rsp_status,
   output logic                                   rsp_found,
   output logic [skvt_pkg::VALUE_WIDTH-1:0]       rsp_found_value,
   output logic [CNT_W-1:0]                       rsp_position,
   output logic [CNT_W-1:0]                       rsp_entry_count,
   output logic [CNT_W-1:0]                       entry_total
);

   localparam int VW = skvt_pkg::VALUE_WIDTH;

   // Cell row
   logic [KEY_WIDTH-1:0] key_ff [DEPTH];
   logic [KEY_WIDTH-1:0] key_in [DEPTH];
   logic [VW-1:0]        val_ff [DEPTH];
   logic [VW-1:0]        val_in [DEPTH];
   logic [CNT_W-1:0]     count_ff;
   logic [CNT_W-1:0]     count_in;

   // Latched request and per-cell compare flags
   logic [skvt_pkg::FUNC_WIDTH-1:0] func_ff;
   logic [KEY_WIDTH-1:0]            rkey_ff;
   logic [VW-1:0]                   rval_ff;
   logic [DEPTH-1:0]                lt_ff;
   logic [DEPTH-1:0]                lt_in;
   logic [DEPTH-1:0]                eq_ff;
   logic [DEPTH-1:0]                eq_in;

   // Response registers
   logic [skvt_pkg::STATUS_WIDTH-1:0] status_ff;
   logic [skvt_pkg::STATUS_WIDTH-1:0] status_in;
   logic                              found_ff;
   logic [VW-1:0]                     fval_ff;
   logic [VW-1:0]                     fval_out;
   logic [CNT_W-1:0]                  pos_ff;

   logic [DEPTH-1:0] first;
   logic [CNT_W-1:0] pos;
   logic [VW-1:0]    hit_val;
   logic             hit;
   logic             full;
   logic             do_insert;
   logic             do_update;
   logic             do_erase;

   // lt flags form a thermometer; the first clear flag is the lower bound.
   assign first     = ~lt_ff & {lt_ff[DEPTH-2:0], 1'b1};
   assign hit       = |eq_ff;
   assign full      = (count_ff == CNT_W'(DEPTH));
   assign do_insert = (func_ff == skvt_pkg::FUNC_INSERT) && !hit && !full;
   assign do_update = (func_ff == skvt_pkg::FUNC_INSERT) && hit;
   assign do_erase  = (func_ff == skvt_pkg::FUNC_ERASE) && hit;

   always_comb begin
      pos     = '0;
      hit_val = '0;
      for (int i = 0; i < DEPTH; i++) begin
         if (first[i]) pos = pos | CNT_W'(i);
         if (eq_ff[i]) hit_val = hit_val | val_ff[i];
      end
      if (&lt_ff) pos = CNT_W'(DEPTH);
   end

   always_comb begin
      count_in  = count_ff;
      fval_out  = '0;
      status_in = skvt_pkg::STATUS_NOT_FOUND;
      case (func_ff)
         skvt_pkg::FUNC_INSERT: begin
            if (hit) begin
               status_in = skvt_pkg::STATUS_EXISTED;
               fval_out  = hit_val;
            end else if (full) begin
               status_in = skvt_pkg::STATUS_FULL;
            end else begin
               status_in = skvt_pkg::STATUS_DONE;
               count_in  = count_ff + CNT_W'(1);
            end
         end
         skvt_pkg::FUNC_ERASE: begin
            if (hit) begin
               status_in = skvt_pkg::STATUS_DONE;
               count_in  = count_ff - CNT_W'(1);
            end
         end
         default: begin
            if (hit) begin
               status_in = skvt_pkg::STATUS_EXISTED;
               fval_out  = hit_val;
            end
         end
      endcase
   end

   for (genvar g = 0; g < DEPTH; g++) begin : g_cell
      logic [KEY_WIDTH-1:0] prev_key;
      logic [VW-1:0]        prev_val;
      logic [KEY_WIDTH-1:0] next_key;
      logic [VW-1:0]        next_val;

      if (g == 0) begin : g_head
         assign prev_key = rkey_ff;
         assign prev_val = rval_ff;
      end else begin : g_mid
         assign prev_key = key_ff[g-1];
         assign prev_val = val_ff[g-1];
      end

      if (g == DEPTH - 1) begin : g_tail
         assign next_key = key_ff[g];
         assign next_val = val_ff[g];
      end else begin : g_body
         assign next_key = key_ff[g+1];
         assign next_val = val_ff[g+1];
      end

      assign lt_in[g] = (CNT_W'(g) < count_ff) && ($signed(key_ff[g]) < req_key);
      assign eq_in[g] = (CNT_W'(g) < count_ff) && (key_ff[g] == req_key);

      always_comb begin
         key_in[g] = key_ff[g];
         val_in[g] = val_ff[g];
         if (cmd.commit) begin
            if (do_insert && !lt_ff[g]) begin
               if (first[g]) begin
                  key_in[g] = rkey_ff;
                  val_in[g] = rval_ff;
               end else begin
                  key_in[g] = prev_key;
                  val_in[g] = prev_val;
               end
            end else if (do_update && eq_ff[g]) begin
               val_in[g] = rval_ff;
            end else if (do_erase && !lt_ff[g]) begin
               key_in[g] = next_key;
               val_in[g] = next_val;
            end
         end
      end

      always_ff @(posedge clock) begin
         key_ff[g] <= key_in[g];
         val_ff[g] <= val_in[g];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else if (cmd.commit) begin
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         func_ff <= req_func;
         rkey_ff <= req_key;
         rval_ff <= req_value;
         lt_ff   <= lt_in;
         eq_ff   <= eq_in;
      end
      if (cmd.commit) begin
         status_ff <= status_in;
         found_ff  <= hit;
         fval_ff   <= fval_out;
         pos_ff    <= pos;
      end
   end

   logic [CNT_W-1:0] count_out_ff;

   always_ff @(posedge clock) begin
      if (cmd.commit) count_out_ff <= count_in;
   end

   assign rsp_status      = status_ff;
   assign rsp_found       = found_ff;
   assign rsp_found_value = fval_ff;
   assign rsp_position    = pos_ff;
   assign rsp_entry_count = count_out_ff;
   assign entry_total     = count_ff;

endmodule

FILE: src/sorted_key_value_table_core.sv
// Top level of the sorted key/value table: controller plus cell-row datapath.
// Depends on skvt_pkg, skvt_ctrl and skvt_datapath.
//
//   channel | direction | ports                                   | handshake
//   req     | in        | req_func, req_key, req_value            | req_valid / req_ready
//   rsp     | out       | rsp_status, rsp_found, rsp_found_value, | rsp_valid / rsp_ready
//           |           | rsp_position, rsp_entry_count           |
//
// A transaction latches the request and every cell's compare result at the
// accept edge, then shifts the cell row and loads the response registers at
// the commit edge. The cell row is updated once per transaction.
// Synchronous reset empties the table; no clearing pass is needed.
// A response waiting on rsp_ready holds the commit edge of the next transaction.
`timescale 1ns / 1ps

module sorted_key_value_table_core #(
   parameter int DEPTH     = skvt_pkg::DEPTH_DEFAULT,
   parameter int KEY_WIDTH = skvt_pkg::KEY_WIDTH_DEFAULT
) (
   input  logic                                     clock,
   input  logic                                     reset,
   input  logic                                     req_valid,
   output logic                                     req_ready,
   input  logic [skvt_pkg::FUNC_WIDTH-1:0]          req_func,
   input  logic signed [KEY_WIDTH-1:0]              req_key,
   input  logic [skvt_pkg::VALUE_WIDTH-1:0]         req_value,
   output logic                                     rsp_valid,
   input  logic                                     rsp_ready,
   output logic [skvt_pkg::STATUS_WIDTH-1:0]        rsp_status,
   output logic                                     rsp_found,
   output logic [skvt_pkg::VALUE_WIDTH-1:0]         rsp_found_value,
   output logic [skvt_pkg::OUT_CNT_WIDTH-1:0]       rsp_position,
   output logic [skvt_pkg::OUT_CNT_WIDTH-1:0]       rsp_entry_count
);

   localparam int CNT_W = $clog2(DEPTH + 1);
   localparam int OW    = skvt_pkg::OUT_CNT_WIDTH;

   skvt_pkg::dp_cmd_type cmd;
   logic [CNT_W-1:0]     position;
   logic [CNT_W-1:0]     entry_count;
   logic [CNT_W-1:0]     entry_total;

   skvt_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .cmd       (cmd)
   );

   skvt_datapath #(
      .DEPTH     (DEPTH),
      .KEY_WIDTH (KEY_WIDTH)
   ) u_datapath (
      .clock           (clock),
      .reset           (reset),
      .cmd             (cmd),
      .req_func        (req_func),
      .req_key         (req_key),
      .req_value       (req_value),
      .rsp_status      (rsp_status),
      .rsp_found       (rsp_found),
      .rsp_found_value (rsp_found_value),
      .rsp_position    (position),
      .rsp_entry_count (entry_count),
      .entry_total     (entry_total)
   );

   assign rsp_position    = OW'(position);
   assign rsp_entry_count = OW'(entry_count);

   // Table never holds more than DEPTH entries.
   assert property (@(posedge clock) disable iff (reset)
      entry_total <= CNT_W'(DEPTH))
      else $error("entry count above table depth");

   // Entry count moves by at most one per transaction.
   assert property (@(posedge clock) disable iff (reset)
      !$past(reset) |-> (entry_total <= $past(entry_total) + CNT_W'(1)) &&
                        (entry_total + CNT_W'(1) >= $past(entry_total)))
      else $error("entry count jumped by more than one");

   // One transaction at a time: no accept right after an accept.
   assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> !req_ready)
      else $error("request accepted while previous one in flight");

   // Full and not-found responses never report a hit or a value.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_status == skvt_pkg::STATUS_FULL ||
                    rsp_status == skvt_pkg::STATUS_NOT_FOUND)
      |-> !rsp_found && (rsp_found_value == '0))
      else $error("miss response carries a hit");

endmodule
